// ===== sv/lpwm_pkg.sv =====
// Shared types, codes and constants for the LED PWM dimmer with breathing.
// Used by lpwm_ctrl, lpwm_scale and led_pwm_dimmer_breathing_core.
`default_nettype none

package lpwm_pkg;

  localparam int PERIOD_BITS_DEF  = 16;
  localparam int STEP_PERCENT_DEF = 25;

  localparam int DUTY_W = 7;
  localparam int CMP_W  = 16;
  localparam int REG_W  = 16;   // width of the timer period register
  localparam int DIV_W  = 17;   // wide enough for a divisor of 100000

  // Command codes carried in req_type.
  localparam logic [3:0] REQ_OPEN   = 4'd0;
  localparam logic [3:0] REQ_CLOSE  = 4'd1;
  localparam logic [3:0] REQ_BON    = 4'd2;
  localparam logic [3:0] REQ_BOFF   = 4'd3;
  localparam logic [3:0] REQ_UP     = 4'd4;
  localparam logic [3:0] REQ_DOWN   = 4'd5;
  localparam logic [3:0] REQ_CYCLE  = 4'd6;
  localparam logic [3:0] REQ_THREE  = 4'd7;
  localparam logic [3:0] REQ_TICK   = 4'd8;

  // Tone codes.
  localparam logic [2:0] TONE_NONE = 3'd0;
  localparam logic [2:0] TONE_OK   = 3'd1;
  localparam logic [2:0] TONE_MAX  = 3'd2;
  localparam logic [2:0] TONE_MIN  = 3'd3;
  localparam logic [2:0] TONE_FAIL = 3'd4;

  // Three-level result codes.
  localparam logic [1:0] MODE_CLOSED = 2'd0;
  localparam logic [1:0] MODE_OPENED = 2'd1;
  localparam logic [1:0] MODE_SET70  = 2'd2;
  localparam logic [1:0] MODE_SET30  = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_PERIOD   = 2'd0;
  localparam logic [1:0] REG_DIGITS   = 2'd1;
  localparam logic [1:0] REG_PRESCALE = 2'd2;

  localparam logic [REG_W-1:0] PERIOD_RST   = 16'd1000;
  localparam logic [1:0]       DIGITS_RST   = 2'd0;
  localparam logic [2:0]       PRESCALE_RST = 3'd3;

  // Brightness constants.
  localparam logic [DUTY_W-1:0] LVL_FULL   = 7'd100;
  localparam logic [DUTY_W-1:0] LVL_HIGH   = 7'd70;
  localparam logic [DUTY_W-1:0] LVL_LOW    = 7'd30;
  localparam logic [DUTY_W-1:0] BREATH_MIN = 7'd2;

  typedef struct packed {
    logic              open;      // output open after the command
    logic              put;       // command writes a new duty
    logic [DUTY_W-1:0] put_duty;  // duty to be written
    logic [DUTY_W-1:0] duty;      // duty shown in the result word
    logic [2:0]        tone;
    logic [1:0]        mode;
  } ctl_res_t;

  // Divisor 100 * 10^digits.
  function automatic logic [DIV_W-1:0] div_for(input logic [1:0] digits);
    logic [DIV_W-1:0] d;
    begin
      case (digits)
        2'd0:    d = 17'd100;
        2'd1:    d = 17'd1000;
        2'd2:    d = 17'd10000;
        default: d = 17'd100000;
      endcase
      return d;
    end
  endfunction

endpackage

`default_nettype wire

// ===== sv/lpwm_scale.sv =====
// Bit-serial compare value unit: shift-add multiply of period by duty,
// then restoring division by 100*10^digits. Depends on lpwm_pkg.
`default_nettype none

module lpwm_scale #(
  parameter int PER_W = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [PER_W-1:0]          per_i,
  input  wire logic [lpwm_pkg::DUTY_W-1:0] duty_i,
  input  wire logic [1:0]                digits_i,
  output logic                           done_o,
  output logic [lpwm_pkg::CMP_W-1:0]     cmp_o
);

  localparam int PROD_W = PER_W + lpwm_pkg::DUTY_W;
  localparam int CNT_W  = $clog2(PROD_W);
  localparam int DV_W   = lpwm_pkg::DIV_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]                  state_q, state_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic [PROD_W-1:0]           acc_q, acc_d;
  logic [PER_W-1:0]            per_q, per_d;
  logic [lpwm_pkg::DUTY_W-1:0] duty_q, duty_d;
  logic [DV_W-1:0]             div_q, div_d;
  logic [DV_W-1:0]             rem_q, rem_d;
  logic [DV_W:0]               trial;
  logic [DV_W:0]               diff;
  logic                        ge;

  always_comb begin
    trial = {rem_q, acc_q[PROD_W-1]};
    diff  = trial - {1'b0, div_q};
    ge    = (trial >= {1'b0, div_q});
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    per_d   = per_q;
    duty_d  = duty_q;
    div_d   = div_q;
    rem_d   = rem_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          acc_d   = '0;
          rem_d   = '0;
          per_d   = per_i;
          duty_d  = duty_i;
          div_d   = lpwm_pkg::div_for(digits_i);
          cnt_d   = CNT_W'(lpwm_pkg::DUTY_W - 1);
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        // One duty bit per cycle, most significant first.
        acc_d  = {acc_q[PROD_W-2:0], 1'b0}
               + (duty_q[lpwm_pkg::DUTY_W-1] ? PROD_W'(per_q) : '0);
        duty_d = {duty_q[lpwm_pkg::DUTY_W-2:0], 1'b0};
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          cnt_d   = CNT_W'(PROD_W - 1);
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        // The product shifts out at the top while quotient bits enter below.
        rem_d = ge ? diff[DV_W-1:0] : trial[DV_W-1:0];
        acc_d = {acc_q[PROD_W-2:0], ge};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    per_q  <= per_d;
    duty_q <= duty_d;
    div_q  <= div_d;
    rem_q  <= rem_d;
  end

  assign done_o = (state_q == S_DONE);
  assign cmp_o  = lpwm_pkg::CMP_W'(acc_q);

endmodule

`default_nettype wire

// ===== sv/lpwm_ctrl.sv =====
// Command decoder and brightness/breathing state of the LED dimmer.
// Depends on lpwm_pkg for codes, constants and the result struct.
`default_nettype none

module lpwm_ctrl #(
  parameter int STEP_PERCENT = lpwm_pkg::STEP_PERCENT_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            step_i,
  input  wire logic [3:0]      req_i,
  input  wire logic            notice_i,
  input  wire logic [2:0]      prescale_i,
  output lpwm_pkg::ctl_res_t   res_o
);

  localparam int DW = lpwm_pkg::DUTY_W;
  localparam logic [DW:0]   STEP8     = (DW+1)'(STEP_PERCENT);
  localparam logic [DW-1:0] STEP7     = DW'(STEP_PERCENT);
  localparam logic [DW:0]   TWO_STEP  = (DW+1)'(2 * STEP_PERCENT);
  localparam logic [DW:0]   FULL8     = {1'b0, lpwm_pkg::LVL_FULL};

  logic [DW-1:0] level_q, level_d;
  logic [DW-1:0] saved_q, saved_d;
  logic          open_q, open_d;
  logic          breathing_q, breathing_d;
  logic [DW-1:0] bduty_q, bduty_d;
  logic          rising_q, rising_d;
  logic [2:0]    pcount_q, pcount_d;
  logic [DW-1:0] last_q, last_d;

  logic [DW-1:0] lo_level;
  logic [DW:0]   up_sum;
  logic [2:0]    presc;
  logic [3:0]    pc_inc;
  logic          rise_t;
  logic [DW-1:0] nl;
  logic [2:0]    tone;
  logic [1:0]    mode;
  logic          put;
  logic [DW-1:0] put_duty;

  always_comb begin
    lo_level = (saved_q != '0) ? saved_q
             : ((level_q == '0) ? lpwm_pkg::LVL_FULL : level_q);
    up_sum   = {1'b0, level_q} + STEP8;
    presc    = (prescale_i == 3'd0) ? 3'd1 : prescale_i;
    pc_inc   = {1'b0, pcount_q} + 4'd1;
    rise_t   = (bduty_q >= lpwm_pkg::LVL_FULL) ? 1'b0
             : ((bduty_q <= lpwm_pkg::BREATH_MIN) ? 1'b1 : rising_q);

    level_d     = level_q;
    saved_d     = saved_q;
    open_d      = open_q;
    breathing_d = breathing_q;
    bduty_d     = bduty_q;
    rising_d    = rising_q;
    pcount_d    = pcount_q;
    tone        = lpwm_pkg::TONE_NONE;
    mode        = lpwm_pkg::MODE_CLOSED;
    put         = 1'b0;
    put_duty    = '0;
    nl          = level_q;

    unique case (req_i) inside
      lpwm_pkg::REQ_OPEN: begin
        level_d     = lo_level;
        saved_d     = lo_level;
        open_d      = 1'b1;
        put         = 1'b1;
        put_duty    = lo_level;
        breathing_d = 1'b0;
        bduty_d     = lpwm_pkg::LVL_FULL;
        tone        = notice_i ? lpwm_pkg::TONE_OK : lpwm_pkg::TONE_NONE;
      end
      lpwm_pkg::REQ_CLOSE, lpwm_pkg::REQ_BOFF: begin
        if (notice_i) begin
          tone = open_q ? lpwm_pkg::TONE_OK : lpwm_pkg::TONE_FAIL;
        end
        level_d     = '0;
        open_d      = 1'b0;
        breathing_d = 1'b0;
        bduty_d     = '0;
        if (req_i == lpwm_pkg::REQ_BOFF) begin
          rising_d = 1'b0;
        end
      end
      lpwm_pkg::REQ_BON: begin
        level_d     = lo_level;
        saved_d     = lo_level;
        open_d      = 1'b1;
        put         = 1'b1;
        put_duty    = lo_level;
        bduty_d     = lo_level;
        rising_d    = 1'b1;
        breathing_d = 1'b1;
        tone        = notice_i ? lpwm_pkg::TONE_OK : lpwm_pkg::TONE_NONE;
      end
      lpwm_pkg::REQ_UP, lpwm_pkg::REQ_DOWN, lpwm_pkg::REQ_CYCLE: begin
        if (level_q == '0 || !open_q) begin
          tone = notice_i ? lpwm_pkg::TONE_FAIL : lpwm_pkg::TONE_NONE;
        end else begin
          if (req_i == lpwm_pkg::REQ_CYCLE) begin
            nl = (up_sum > FULL8) ? STEP7 : up_sum[DW-1:0];
          end else if (req_i == lpwm_pkg::REQ_UP) begin
            if (up_sum > FULL8) begin
              nl   = lpwm_pkg::LVL_FULL;
              tone = lpwm_pkg::TONE_MAX;
            end else begin
              nl   = up_sum[DW-1:0];
              tone = lpwm_pkg::TONE_OK;
            end
          end else begin
            if ({1'b0, level_q} < TWO_STEP) begin
              nl   = STEP7;
              tone = lpwm_pkg::TONE_MIN;
            end else begin
              nl   = level_q - STEP7;
              tone = lpwm_pkg::TONE_OK;
            end
          end
          if (!notice_i) begin
            tone = lpwm_pkg::TONE_NONE;
          end
          level_d  = nl;
          saved_d  = nl;
          put      = 1'b1;
          put_duty = nl;
        end
      end
      lpwm_pkg::REQ_THREE: begin
        if (open_q && level_q == lpwm_pkg::LVL_FULL) begin
          level_d  = lpwm_pkg::LVL_HIGH;
          saved_d  = lpwm_pkg::LVL_HIGH;
          put      = 1'b1;
          put_duty = lpwm_pkg::LVL_HIGH;
          mode     = lpwm_pkg::MODE_SET70;
        end else if (open_q && level_q == lpwm_pkg::LVL_HIGH) begin
          level_d  = lpwm_pkg::LVL_LOW;
          saved_d  = lpwm_pkg::LVL_LOW;
          put      = 1'b1;
          put_duty = lpwm_pkg::LVL_LOW;
          mode     = lpwm_pkg::MODE_SET30;
        end else if (open_q && level_q == lpwm_pkg::LVL_LOW) begin
          level_d = '0;
          saved_d = '0;
          open_d  = 1'b0;
          mode    = lpwm_pkg::MODE_CLOSED;
        end else begin
          level_d  = lo_level;
          saved_d  = lo_level;
          open_d   = 1'b1;
          put      = 1'b1;
          put_duty = lo_level;
          mode     = lpwm_pkg::MODE_OPENED;
        end
      end
      lpwm_pkg::REQ_TICK: begin
        if (breathing_q) begin
          rising_d = rise_t;
          if (pcount_q == 3'd0) begin
            bduty_d  = rise_t ? (bduty_q + 1'b1) : (bduty_q - 1'b1);
            // The ramp keeps moving while the output is closed.
            put      = open_q;
            put_duty = bduty_d;
          end
          pcount_d = (pc_inc >= {1'b0, presc}) ? 3'd0 : pc_inc[2:0];
        end
      end
      default: begin
      end
    endcase

    last_d = put ? put_duty : (open_d ? last_q : '0);

    res_o.open     = open_d;
    res_o.put      = put;
    res_o.put_duty = put_duty;
    res_o.duty     = open_d ? last_d : '0;
    res_o.tone     = tone;
    res_o.mode     = mode;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q     <= '0;
      saved_q     <= '0;
      open_q      <= 1'b0;
      breathing_q <= 1'b0;
      bduty_q     <= '0;
      rising_q    <= 1'b0;
      pcount_q    <= '0;
      last_q      <= '0;
    end else if (step_i) begin
      level_q     <= level_d;
      saved_q     <= saved_d;
      open_q      <= open_d;
      breathing_q <= breathing_d;
      bduty_q     <= bduty_d;
      rising_q    <= rising_d;
      pcount_q    <= pcount_d;
      last_q      <= last_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/led_pwm_dimmer_breathing_core.sv =====
// Top level of the LED PWM dimmer with breathing: stream ports, APB
// registers, result register. Depends on lpwm_pkg, lpwm_ctrl, lpwm_scale.
//
//   Port group   Dir   Payload
//   s_axis_*     in    command word: req_type, notice
//   m_axis_*     out   result word: enable, duty, compare, written, tone, mode
//   APB          in    timer_period (0x0), fraction_digits (0x4), prescale (0x8)
//
// A command that writes no duty goes straight to ST_HOLD. A command that
// writes a duty first waits in ST_CALC while lpwm_scale runs its bit-serial
// multiply (7 steps) and restoring divide (PER_W + 7 steps, where PER_W =
// min(PERIOD_BITS, 16)). Commands are taken only in ST_IDLE.
// A new command is taken while the previous result word still waits in the
// output register. Reset is asynchronous and needs no clearing pass.
`default_nettype none

module led_pwm_dimmer_breathing_core #(
  parameter int PERIOD_BITS  = lpwm_pkg::PERIOD_BITS_DEF,
  parameter int STEP_PERCENT = lpwm_pkg::STEP_PERCENT_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [3:0] req_type, [4] notice
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [0] pwm_enable, [7:1] duty_percent, [23:8] compare_value,
  // [24] compare_written, [27:25] tone_code, [29:28] mode_code
  output logic [31:0]      m_axis_tdata,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int PER_W = (PERIOD_BITS < lpwm_pkg::REG_W) ? PERIOD_BITS : lpwm_pkg::REG_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [lpwm_pkg::REG_W-1:0] period_q;
  logic [1:0]                 digits_q;
  logic [2:0]                 prescale_q;
  logic                       wr_en;

  logic [1:0]                 state_q, state_d;
  logic                       accept;
  lpwm_pkg::ctl_res_t         ctl_res;
  lpwm_pkg::ctl_res_t         pend_q;
  logic [lpwm_pkg::CMP_W-1:0] last_cmp_q;
  logic                       scl_done;
  logic [lpwm_pkg::CMP_W-1:0] scl_cmp;
  logic                       load;
  logic                       out_valid_q;
  logic [31:0]                out_data_q, out_data_d;

  // Configuration registers.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q   <= lpwm_pkg::PERIOD_RST;
      digits_q   <= lpwm_pkg::DIGITS_RST;
      prescale_q <= lpwm_pkg::PRESCALE_RST;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        lpwm_pkg::REG_PERIOD:   period_q   <= pwdata[lpwm_pkg::REG_W-1:0];
        lpwm_pkg::REG_DIGITS:   digits_q   <= pwdata[1:0];
        lpwm_pkg::REG_PRESCALE: prescale_q <= pwdata[2:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      lpwm_pkg::REG_PERIOD:   prdata = 32'(period_q);
      lpwm_pkg::REG_DIGITS:   prdata = 32'(digits_q);
      lpwm_pkg::REG_PRESCALE: prdata = 32'(prescale_q);
      default:                prdata = '0;
    endcase
  end

  // Command handling.
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  lpwm_ctrl #(
    .STEP_PERCENT(STEP_PERCENT)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (accept),
    .req_i      (s_axis_tdata[3:0]),
    .notice_i   (s_axis_tdata[4]),
    .prescale_i (prescale_q),
    .res_o      (ctl_res)
  );

  lpwm_scale #(
    .PER_W(PER_W)
  ) u_scale (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (accept && ctl_res.put),
    .per_i    (period_q[PER_W-1:0]),
    .duty_i   (ctl_res.put_duty),
    .digits_i (digits_q),
    .done_o   (scl_done),
    .cmp_o    (scl_cmp)
  );

  assign load = (state_q == ST_HOLD) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ctl_res.put ? ST_CALC : ST_HOLD;
        end
      end
      ST_CALC: begin
        if (scl_done) begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      last_cmp_q  <= '0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (scl_done) begin
        last_cmp_q <= scl_cmp;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_q <= ctl_res;
    end
  end

  always_comb begin
    out_data_d        = '0;
    out_data_d[0]     = pend_q.open;
    out_data_d[7:1]   = pend_q.duty;
    out_data_d[23:8]  = pend_q.open ? last_cmp_q : '0;
    out_data_d[24]    = pend_q.put;
    out_data_d[27:25] = pend_q.tone;
    out_data_d[29:28] = pend_q.mode;
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // The serial unit only finishes while a command waits for its compare.
  a_done_in_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scl_done |-> (state_q == ST_CALC))
    else $error("compare unit finished outside a calculation");

  // A command that writes a duty always starts the compare calculation.
  a_put_starts_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && ctl_res.put) |=> (state_q == ST_CALC))
    else $error("duty write did not start the compare calculation");

  // A closed output shows zero duty and zero compare.
  a_closed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[23:1] == '0))
    else $error("closed output word carries a duty or compare");

  // A compare write only happens with the output open.
  a_write_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[24]) |-> m_axis_tdata[0])
    else $error("compare written while the output is closed");

endmodule

`default_nettype wire

// ===== tb/led_pwm_dimmer_breathing_core_test.sv =====
// Self-checking testbench for led_pwm_dimmer_breathing_core: drives command words,
// predicts each result word in a behavioral model and checks it field by field.
// Depends on lpwm_pkg and the core with its submodules.

module led_pwm_dimmer_breathing_core_test;

  localparam int IDLE_LIMIT = 4000;   // cycles without any handshake
  localparam int SETTLE     = 48;     // longer than one compare computation
  localparam int HOLD_LEN   = 300;    // long output stall to back up the core
  localparam logic [3:0] REQ_SPARE_TOP = 4'hF;
  localparam logic [lpwm_pkg::DUTY_W-1:0] STEP =
    lpwm_pkg::DUTY_W'(lpwm_pkg::STEP_PERCENT_DEF);

  typedef struct packed {
    logic                        en;
    logic [lpwm_pkg::DUTY_W-1:0] duty;
    logic [lpwm_pkg::CMP_W-1:0]  cmp;
    logic                        wr;
    logic [2:0]                  tone;
    logic [1:0]                  mode;
  } dim_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [3:0] req_type, [4] notice
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [0] pwm_enable, [7:1] duty_percent, [23:8] compare_value,
  // [24] compare_written, [27:25] tone_code, [29:28] mode_code
  logic [31:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  led_pwm_dimmer_breathing_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #1 clk_i = ~clk_i;

  // Dimmer state as the core should hold it.
  logic [lpwm_pkg::REG_W-1:0]  cfg_period   = lpwm_pkg::PERIOD_RST;
  logic [1:0]                  cfg_digits   = lpwm_pkg::DIGITS_RST;
  logic [2:0]                  cfg_prescale = lpwm_pkg::PRESCALE_RST;
  logic [lpwm_pkg::DUTY_W-1:0] lvl = '0, saved_lvl = '0, br_duty = '0, last_duty = '0;
  logic [lpwm_pkg::CMP_W-1:0]  last_cmp = '0;
  logic              out_open = 1'b0, breathing = 1'b0, br_rising = 1'b0, wrote = 1'b0;
  logic [2:0]        pre_cnt = '0;

  logic [7:0] cmd_q[$];
  dim_res_t   result_q[$];
  int         mismatches = 0;
  int         rx_count = 0;
  int         src_gap = 0, sink_gap = 0, hold_left = 0;
  bit         hold_done = 1'b0;
  bit         calm = 1'b0;
  int         idle_cycles = 0;

  function automatic void duty_write(input logic [lpwm_pkg::DUTY_W-1:0] duty);
    logic [31:0] divisor;
    logic [31:0] prod;
    if (!out_open) return;
    case (cfg_digits)
      2'd0:    divisor = 32'd100;
      2'd1:    divisor = 32'd1000;
      2'd2:    divisor = 32'd10000;
      default: divisor = 32'd100000;
    endcase
    prod = 32'(cfg_period) * 32'(duty);
    last_duty = duty;
    last_cmp = 16'(prod / divisor);
    wrote = 1'b1;
  endfunction

  function automatic void lamp_on();
    if (saved_lvl != 0) lvl = saved_lvl;
    else if (lvl == 0) lvl = lpwm_pkg::LVL_FULL;
    saved_lvl = lvl;
    out_open = 1'b1;
    last_duty = '0;
    last_cmp = '0;
    duty_write(lvl);
  endfunction

  function automatic logic lamp_off();
    lvl = '0;
    if (out_open) begin
      out_open = 1'b0;
      last_duty = '0;
      last_cmp = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Applies one command to the dimmer state and returns the result word it gives.
  function automatic dim_res_t dim_predict(input logic [3:0] req, input logic notice);
    logic [2:0] tone;
    logic [1:0] mode;
    logic [2:0] presc;
    logic [3:0] cnt_next;
    dim_res_t   r;
    wrote = 1'b0;
    tone = lpwm_pkg::TONE_NONE;
    mode = lpwm_pkg::MODE_CLOSED;
    case (req)
      lpwm_pkg::REQ_OPEN: begin
        lamp_on();
        breathing = 1'b0;
        br_duty = lpwm_pkg::LVL_FULL;
        if (notice) tone = lpwm_pkg::TONE_OK;
      end
      lpwm_pkg::REQ_CLOSE, lpwm_pkg::REQ_BOFF: begin
        tone = lamp_off() ? lpwm_pkg::TONE_OK : lpwm_pkg::TONE_FAIL;
        if (!notice) tone = lpwm_pkg::TONE_NONE;
        breathing = 1'b0;
        br_duty = '0;
        if (req == lpwm_pkg::REQ_BOFF) br_rising = 1'b0;
      end
      lpwm_pkg::REQ_BON: begin
        lamp_on();
        br_duty = saved_lvl;
        br_rising = 1'b1;
        breathing = 1'b1;
        if (notice) tone = lpwm_pkg::TONE_OK;
      end
      lpwm_pkg::REQ_UP, lpwm_pkg::REQ_DOWN, lpwm_pkg::REQ_CYCLE: begin
        if (lvl == 0 || !out_open) begin
          if (notice) tone = lpwm_pkg::TONE_FAIL;
        end else begin
          if (req == lpwm_pkg::REQ_CYCLE) begin
            // Cycle step wraps and stays silent even when asked for a tone.
            lvl = lvl + STEP;
            if (lvl > lpwm_pkg::LVL_FULL) lvl = STEP;
          end else if (req == lpwm_pkg::REQ_UP) begin
            lvl = lvl + STEP;
            if (lvl > lpwm_pkg::LVL_FULL) begin
              lvl = lpwm_pkg::LVL_FULL;
              tone = lpwm_pkg::TONE_MAX;
            end else begin
              tone = lpwm_pkg::TONE_OK;
            end
          end else if (lvl < STEP + STEP) begin
            lvl = STEP;
            tone = lpwm_pkg::TONE_MIN;
          end else begin
            lvl = lvl - STEP;
            tone = lpwm_pkg::TONE_OK;
          end
          if (!notice) tone = lpwm_pkg::TONE_NONE;
          saved_lvl = lvl;
          duty_write(lvl);
        end
      end
      lpwm_pkg::REQ_THREE: begin
        if (!out_open) begin
          lamp_on();
          mode = lpwm_pkg::MODE_OPENED;
        end else if (lvl == lpwm_pkg::LVL_FULL) begin
          lvl = lpwm_pkg::LVL_HIGH;
          saved_lvl = lpwm_pkg::LVL_HIGH;
          duty_write(lpwm_pkg::LVL_HIGH);
          mode = lpwm_pkg::MODE_SET70;
        end else if (lvl == lpwm_pkg::LVL_HIGH) begin
          lvl = lpwm_pkg::LVL_LOW;
          saved_lvl = lpwm_pkg::LVL_LOW;
          duty_write(lpwm_pkg::LVL_LOW);
          mode = lpwm_pkg::MODE_SET30;
        end else if (lvl == lpwm_pkg::LVL_LOW) begin
          lvl = '0;
          saved_lvl = '0;
          void'(lamp_off());
          mode = lpwm_pkg::MODE_CLOSED;
        end else begin
          lamp_on();
          mode = lpwm_pkg::MODE_OPENED;
        end
      end
      lpwm_pkg::REQ_TICK: begin
        if (breathing) begin
          if (br_duty >= lpwm_pkg::LVL_FULL) br_rising = 1'b0;
          else if (br_duty <= lpwm_pkg::BREATH_MIN) br_rising = 1'b1;
          presc = (cfg_prescale < 3'd1) ? 3'd1 : cfg_prescale;
          if (pre_cnt == 0) begin
            br_duty = br_rising ? br_duty + 1'b1 : br_duty - 1'b1;
            duty_write(br_duty);
          end
          cnt_next = {1'b0, pre_cnt} + 4'd1;
          pre_cnt = (cnt_next >= {1'b0, presc}) ? 3'd0 : cnt_next[2:0];
        end
      end
      default: begin
      end
    endcase
    r.en   = out_open;
    r.duty = out_open ? last_duty : '0;
    r.cmp  = out_open ? last_cmp : '0;
    r.wr   = wrote;
    r.tone = tone;
    r.mode = mode;
    return r;
  endfunction

  function automatic string res_text(input dim_res_t r);
    return $sformatf("en=%0d duty=%0d cmp=%0d wr=%0d tone=%0d mode=%0d",
                     r.en, r.duty, r.cmp, r.wr, r.tone, r.mode);
  endfunction

  function automatic logic [7:0] pack_cmd(input logic [3:0] req, input logic notice);
    return {3'b000, notice, req};
  endfunction

  function automatic logic [7:0] rand_cmd();
    int         pick;
    logic [3:0] req;
    pick = $urandom_range(0, 99);
    if (pick < 6) req = 4'($urandom_range(lpwm_pkg::REQ_TICK + 4'd1, REQ_SPARE_TOP));
    else if (pick < 40) req = lpwm_pkg::REQ_TICK;
    else req = 4'($urandom_range(lpwm_pkg::REQ_OPEN, lpwm_pkg::REQ_THREE));
    return pack_cmd(req, 1'($urandom_range(0, 1)));
  endfunction

  // Mostly breathing runs (breath on, then a long train of ticks with an
  // occasional command mixed in), the rest short bursts of any command.
  task automatic queue_random(input int n_items);
    int queued;
    int len;
    queued = 0;
    while (queued < n_items) begin
      if ($urandom_range(0, 2) != 0) begin
        cmd_q.push_back(pack_cmd(lpwm_pkg::REQ_BON, 1'($urandom_range(0, 1))));
        len = $urandom_range(10, 120);
        repeat (len) begin
          if ($urandom_range(0, 19) == 0) cmd_q.push_back(rand_cmd());
          else cmd_q.push_back(pack_cmd(lpwm_pkg::REQ_TICK, 1'($urandom_range(0, 1))));
        end
        queued += len + 1;
      end else begin
        len = $urandom_range(1, 12);
        repeat (len) cmd_q.push_back(rand_cmd());
        queued += len;
      end
    end
  endtask

  task automatic drain();
    while (cmd_q.size() != 0 || s_axis_tvalid || result_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      lpwm_pkg::REG_PERIOD:   cfg_period = value[lpwm_pkg::REG_W-1:0];
      lpwm_pkg::REG_DIGITS:   cfg_digits = value[1:0];
      lpwm_pkg::REG_PRESCALE: cfg_prescale = value[2:0];
      default: begin
      end
    endcase
  endtask

  task automatic run_phase(input logic [15:0] period, input logic [1:0] digits,
                           input logic [2:0] prescale, input int n_items);
    reg_write(lpwm_pkg::REG_PERIOD, 32'(period));
    reg_write(lpwm_pkg::REG_DIGITS, 32'(digits));
    reg_write(lpwm_pkg::REG_PRESCALE, 32'(prescale));
    queue_random(n_items);
    drain();
  endtask

  initial begin : stimulus
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset register values.
    cmd_q.push_back(pack_cmd(lpwm_pkg::REQ_TICK, 1'b1));    // not breathing yet
    cmd_q.push_back(pack_cmd(lpwm_pkg::REQ_UP, 1'b1));      // output closed
    cmd_q.push_back(pack_cmd(lpwm_pkg::REQ_CLOSE, 1'b1));   // already closed
    cmd_q.push_back(pack_cmd(lpwm_pkg::REQ_OPEN, 1'b1));
    cmd_q.push_back(pack_cmd(lpwm_pkg::REQ_UP, 1'b1));      // already at full
    cmd_q.push_back(pack_cmd(lpwm_pkg::REQ_DOWN, 1'b1));
    cmd_q.push_back(pack_cmd(lpwm_pkg::REQ_DOWN, 1'b0));
    cmd_q.push_back(pack_cmd(lpwm_pkg::REQ_DOWN, 1'b1));
    cmd_q.push_back(pack_cmd(lpwm_pkg::REQ_DOWN, 1'b1));    // clamps at the bottom step
    cmd_q.push_back(pack_cmd(lpwm_pkg::REQ_CYCLE, 1'b1));
    cmd_q.push_back(pack_cmd(lpwm_pkg::REQ_CYCLE, 1'b0));
    cmd_q.push_back(pack_cmd(lpwm_pkg::REQ_CYCLE, 1'b0));
    cmd_q.push_back(pack_cmd(lpwm_pkg::REQ_CYCLE, 1'b1));   // wraps back to the bottom step
    cmd_q.push_back(pack_cmd(lpwm_pkg::REQ_THREE, 1'b1));   // odd level reopens
    repeat (3) cmd_q.push_back(pack_cmd(lpwm_pkg::REQ_UP, 1'b0));
    repeat (4) cmd_q.push_back(pack_cmd(lpwm_pkg::REQ_THREE, 1'b0));
    cmd_q.push_back(pack_cmd(lpwm_pkg::REQ_BON, 1'b1));
    repeat (3) cmd_q.push_back(pack_cmd(lpwm_pkg::REQ_TICK, 1'b0));
    cmd_q.push_back(pack_cmd(lpwm_pkg::REQ_BOFF, 1'b1));
    cmd_q.push_back(pack_cmd(lpwm_pkg::REQ_BOFF, 1'b1));
    cmd_q.push_back(pack_cmd(REQ_SPARE_TOP, 1'b1));
    cmd_q.push_back(pack_cmd(lpwm_pkg::REQ_TICK + 4'd1, 1'b0));
    queue_random(120);
    drain();

    run_phase(16'hFFFF, 2'd0, 3'd7, 200);
    run_phase(16'd0, 2'd3, 3'd0, 150);
    run_phase(16'd1, 2'd1, 3'd1, 150);
    run_phase(16'hFFFF, 2'd2, 3'd2, 200);
    repeat (2) run_phase(16'($urandom), 2'($urandom), 3'($urandom), 200);
    calm = 1'b1;
    run_phase(16'($urandom), 2'($urandom), 3'($urandom), 200);

    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  // Command word driver.
  always @(posedge clk_i) begin : feed
    logic accepted;
    accepted = rst_ni && s_axis_tvalid && s_axis_tready;
    if (accepted) result_q.push_back(dim_predict(s_axis_tdata[3:0], s_axis_tdata[4]));
    if (rst_ni && (accepted || !s_axis_tvalid)) begin
      if (src_gap > 0) begin
        src_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (cmd_q.size() != 0) begin
        s_axis_tdata  <= cmd_q.pop_front();
        s_axis_tvalid <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) src_gap = $urandom_range(1, 12);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result word monitor and output back-pressure.
  always @(posedge clk_i) begin : sink
    dim_res_t got;
    dim_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.en   = m_axis_tdata[0];
      got.duty = m_axis_tdata[7:1];
      got.cmp  = m_axis_tdata[23:8];
      got.wr   = m_axis_tdata[24];
      got.tone = m_axis_tdata[27:25];
      got.mode = m_axis_tdata[29:28];
      if (result_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("word %0d: unexpected result %s", rx_count, res_text(got));
      end else begin
        want = result_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word %0d: expected %s, got %s", rx_count, res_text(want),
                     res_text(got));
        end
      end
      rx_count++;
    end
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && rx_count >= 100) begin
      // Long stall so the core backs up and stops taking commands.
      hold_done = 1'b1;
      hold_left = HOLD_LEN;
      m_axis_tready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      sink_gap = $urandom_range(0, 11);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable && pready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

endmodule
